[rtl/dtts_pkg.sv]
package dtts_pkg;

  // timer spans (counts per compare period), each in 256 .. 65536
  localparam int unsigned WIDE_TIMER_SPAN     = 65536;
  localparam int unsigned NONBLOCK_TIMER_SPAN = 65536;

  // datapath widths
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned TICKS_W = 27;   // delay * 16 / 1024, rounded, fits 27 bits
  localparam int unsigned SPAN_W  = 17;   // holds a span up to 65536
  localparam int unsigned QUOT_W  = 19;   // ticks / span with span at least 256
  localparam int unsigned RECIP_W = 29;   // reciprocal below 2^28 + 1
  localparam int unsigned CYCLE_W = 11;
  localparam int unsigned CMP_W   = 16;

  // 8-bit timer takes blocking delays below this
  localparam logic [DELAY_W-1:0] SHORT_DELAY_LIMIT = 32'd16384;

  // span constants
  localparam logic [SPAN_W-1:0] WIDE_SPAN = SPAN_W'(WIDE_TIMER_SPAN);
  localparam logic [SPAN_W-1:0] NB_SPAN   = SPAN_W'(NONBLOCK_TIMER_SPAN);

  // exact reciprocal for division by each span: q = (ticks * recip) >> shift
  localparam int unsigned WIDE_SHIFT = TICKS_W + $clog2(WIDE_TIMER_SPAN);
  localparam int unsigned NB_SHIFT   = TICKS_W + $clog2(NONBLOCK_TIMER_SPAN);
  localparam logic [63:0] WIDE_RECIP_64 =
    ((64'd1 << WIDE_SHIFT) + 64'(WIDE_TIMER_SPAN) - 64'd1) / 64'(WIDE_TIMER_SPAN);
  localparam logic [63:0] NB_RECIP_64 =
    ((64'd1 << NB_SHIFT) + 64'(NONBLOCK_TIMER_SPAN) - 64'd1) / 64'(NONBLOCK_TIMER_SPAN);
  localparam logic [RECIP_W-1:0] WIDE_RECIP = WIDE_RECIP_64[RECIP_W-1:0];
  localparam logic [RECIP_W-1:0] NB_RECIP   = NB_RECIP_64[RECIP_W-1:0];

  typedef enum logic {
    CMD_BLOCKING = 1'b0,
    CMD_NONBLOCK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    TIMER_8BIT     = 2'd0,
    TIMER_16BIT    = 2'd1,
    TIMER_NONBLOCK = 2'd2
  } timer_e;

  typedef enum logic [2:0] {
    PRESC_DIV1    = 3'd0,
    PRESC_DIV8    = 3'd1,
    PRESC_DIV64   = 3'd2,
    PRESC_DIV256  = 3'd3,
    PRESC_DIV1024 = 3'd4
  } prescale_e;

  typedef struct packed {
    logic                command;
    logic [DELAY_W-1:0]  delay_us;
  } req_t;

  typedef struct packed {
    logic [1:0]          timer_id;
    logic [2:0]          prescale_code;
    logic [CYCLE_W-1:0]  cycle_count;
    logic [CMP_W-1:0]    compare_value;
    logic                partial_flag;
    logic [CMP_W-1:0]    partial_compare;
  } rsp_t;

  // timer choice, prescaler and tick count of one request
  typedef struct packed {
    timer_e              tid;
    prescale_e           pc;
    logic [TICKS_W-1:0]  ticks;
    logic                split;
  } sel_t;

  // log2 of the prescaler divide
  function automatic logic [3:0] prescale_shift(prescale_e pc);
    logic [3:0] sh;
    case (pc)
      PRESC_DIV1:    sh = 4'd0;
      PRESC_DIV8:    sh = 4'd3;
      PRESC_DIV64:   sh = 4'd6;
      PRESC_DIV256:  sh = 4'd8;
      PRESC_DIV1024: sh = 4'd10;
      default:       sh = 4'd0;
    endcase
    return sh;
  endfunction

  // span of the chosen 16-bit timer
  function automatic logic [SPAN_W-1:0] timer_span(timer_e tid);
    return (tid == TIMER_NONBLOCK) ? NB_SPAN : WIDE_SPAN;
  endfunction

endpackage

[rtl/dtts_select.sv]
module dtts_select (
  input  dtts_pkg::req_t req_i,
  output dtts_pkg::sel_t sel_o
);

  dtts_pkg::timer_e      tid;
  dtts_pkg::prescale_e   pc;
  logic [3:0]            sh;
  logic [10:0]           pow;
  logic [9:0]            rnd;
  logic [36:0]           sum;
  logic [dtts_pkg::TICKS_W-1:0] ticks;
  logic [dtts_pkg::DELAY_W-1:0] d;

  assign d = req_i.delay_us;

  // timer choice
  always_comb begin
    if (dtts_pkg::cmd_e'(req_i.command) == dtts_pkg::CMD_NONBLOCK) begin
      tid = dtts_pkg::TIMER_NONBLOCK;
    end else if (d < dtts_pkg::SHORT_DELAY_LIMIT) begin
      tid = dtts_pkg::TIMER_8BIT;
    end else begin
      tid = dtts_pkg::TIMER_16BIT;
    end
  end

  // prescaler ladders, inclusive upper bounds
  always_comb begin
    if (tid == dtts_pkg::TIMER_8BIT) begin
      if (d <= 32'd16)        pc = dtts_pkg::PRESC_DIV1;
      else if (d <= 32'd128)  pc = dtts_pkg::PRESC_DIV8;
      else if (d <= 32'd1024) pc = dtts_pkg::PRESC_DIV64;
      else if (d <= 32'd4096) pc = dtts_pkg::PRESC_DIV256;
      else                    pc = dtts_pkg::PRESC_DIV1024;
    end else begin
      if (d <= 32'd4096)         pc = dtts_pkg::PRESC_DIV1;
      else if (d <= 32'd32768)   pc = dtts_pkg::PRESC_DIV8;
      else if (d <= 32'd262144)  pc = dtts_pkg::PRESC_DIV64;
      else if (d <= 32'd1048576) pc = dtts_pkg::PRESC_DIV256;
      else                       pc = dtts_pkg::PRESC_DIV1024;
    end
  end

  // ticks = delay * 16 / prescaler; 8-bit timer rounds up, others half away
  always_comb begin
    sh    = dtts_pkg::prescale_shift(pc);
    pow   = 11'd1 << sh;
    rnd   = (tid == dtts_pkg::TIMER_8BIT) ? 10'(pow - 11'd1) : pow[10:1];
    sum   = {1'b0, d, 4'b0000} + {27'd0, rnd};
    ticks = dtts_pkg::TICKS_W'(sum >> sh);
  end

  // long delays at div1024 split into full periods
  always_comb begin
    sel_o.tid   = tid;
    sel_o.pc    = pc;
    sel_o.ticks = ticks;
    sel_o.split = (tid != dtts_pkg::TIMER_8BIT) && (pc == dtts_pkg::PRESC_DIV1024) &&
                  (ticks > {{(dtts_pkg::TICKS_W - dtts_pkg::SPAN_W){1'b0}},
                            dtts_pkg::timer_span(tid)});
  end

endmodule

[rtl/delay_to_timer_settings_top.sv]
// Converts a delay request (blocking or non-blocking, delay in microseconds) into timer
// settings: timer, prescaler, compare value and, for long delays at div1024, a count of full
// compare periods plus an optional shorter final period. One request is accepted every clock
// cycle unless a finished result is stalled; each result passes through four register stages:
// input capture, timer and tick selection, reciprocal multiply for the period count, and the
// remainder multiply feeding the result register. A stalled result holds the whole pipeline.
// The timer spans are package constants and may be any value from 256 to 65536.
module delay_to_timer_settings_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  dtts_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_stall_i,
  output dtts_pkg::rsp_t rsp_o
);

  localparam int unsigned PROD_W  = dtts_pkg::TICKS_W + dtts_pkg::RECIP_W;
  localparam int unsigned PROD2_W = dtts_pkg::QUOT_W + dtts_pkg::SPAN_W;

  logic                          adv;
  logic                          v1_q, v2_q, v3_q, vo_q;
  dtts_pkg::req_t                req_q;
  dtts_pkg::sel_t                sel_d, sel2_q, sel3_q;
  logic [dtts_pkg::RECIP_W-1:0]  recip;
  logic [PROD_W-1:0]             prod;
  logic [dtts_pkg::QUOT_W-1:0]   quot_d, quot_q;
  logic [dtts_pkg::SPAN_W-1:0]   span3;
  logic [PROD2_W-1:0]            prod2;
  logic [dtts_pkg::TICKS_W-1:0]  rem_full;
  logic [dtts_pkg::SPAN_W-1:0]   rem;
  dtts_pkg::rsp_t                rsp_d, rsp_q;

  // pipeline moves unless a finished result is held
  assign adv         = !(vo_q && rsp_stall_i);
  assign req_stall_o = !adv;
  assign rsp_valid_o = vo_q;
  assign rsp_o       = rsp_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= req_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  // timer, prescaler and ticks
  dtts_select u_select (
    .req_i (req_q),
    .sel_o (sel_d)
  );

  // period count via exact reciprocal of the span
  always_comb begin
    recip = (sel2_q.tid == dtts_pkg::TIMER_NONBLOCK) ? dtts_pkg::NB_RECIP :
                                                       dtts_pkg::WIDE_RECIP;
    prod  = {{dtts_pkg::RECIP_W{1'b0}}, sel2_q.ticks} *
            {{dtts_pkg::TICKS_W{1'b0}}, recip};
    if (sel2_q.tid == dtts_pkg::TIMER_NONBLOCK) begin
      quot_d = dtts_pkg::QUOT_W'(prod >> dtts_pkg::NB_SHIFT);
    end else begin
      quot_d = dtts_pkg::QUOT_W'(prod >> dtts_pkg::WIDE_SHIFT);
    end
  end

  // remainder and result fields
  always_comb begin
    span3    = dtts_pkg::timer_span(sel3_q.tid);
    prod2    = {{dtts_pkg::SPAN_W{1'b0}}, quot_q} * {{dtts_pkg::QUOT_W{1'b0}}, span3};
    rem_full = sel3_q.ticks - prod2[dtts_pkg::TICKS_W-1:0];
    rem      = rem_full[dtts_pkg::SPAN_W-1:0];

    rsp_d.timer_id        = sel3_q.tid;
    rsp_d.prescale_code   = sel3_q.pc;
    rsp_d.cycle_count     = dtts_pkg::CYCLE_W'(1);
    rsp_d.partial_flag    = 1'b0;
    rsp_d.partial_compare = '0;
    if (sel3_q.split) begin
      rsp_d.cycle_count   = quot_q[dtts_pkg::CYCLE_W-1:0];
      rsp_d.compare_value = dtts_pkg::CMP_W'(span3 - dtts_pkg::SPAN_W'(1));
      if (rem != '0) begin
        rsp_d.partial_flag    = 1'b1;
        rsp_d.partial_compare = dtts_pkg::CMP_W'(rem - dtts_pkg::SPAN_W'(1));
      end
    end else if (sel3_q.tid == dtts_pkg::TIMER_8BIT) begin
      // zero ticks wraps to 255
      rsp_d.compare_value = {8'd0, sel3_q.ticks[7:0] - 8'd1};
    end else begin
      rsp_d.compare_value = sel3_q.ticks[dtts_pkg::CMP_W-1:0] - dtts_pkg::CMP_W'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      req_q  <= req_i;
      sel2_q <= sel_d;
      sel3_q <= sel2_q;
      quot_q <= quot_d;
      rsp_q  <= rsp_d;
    end
  end

`ifndef SYNTHESIS
  // a split only happens on a 16-bit timer at div1024
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && rsp_q.partial_flag) |->
      (rsp_q.timer_id != dtts_pkg::TIMER_8BIT &&
       rsp_q.prescale_code == dtts_pkg::PRESC_DIV1024))
    else $error("partial period outside a div1024 16-bit split");

  // 8-bit timer results stay within the 8-bit counter and never split
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && rsp_q.timer_id == dtts_pkg::TIMER_8BIT) |->
      (rsp_q.compare_value[15:8] == 8'd0 && rsp_q.cycle_count == dtts_pkg::CYCLE_W'(1)))
    else $error("8-bit timer result out of range");

  // remainder of the span division is below the span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && sel3_q.split) |->
      (rem < span3 && rem_full[dtts_pkg::TICKS_W-1:dtts_pkg::SPAN_W] == '0))
    else $error("span division remainder out of range");

  // an accepted transaction reaches the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && !req_stall_o) |=> v1_q)
    else $error("accepted transaction lost at input stage");
`endif

endmodule

[sim/tb_delay_to_timer_settings_top.sv]
`timescale 1ns / 100ps

module tb_delay_to_timer_settings_top;

  localparam int unsigned PHASE_ITEMS = 600;
  localparam int unsigned DIR_N       = 24;
  localparam int unsigned HOLD_CYCLES = 300;
  // long receiver hold lands inside the third phase, where nobody idles
  localparam int unsigned HOLD_AT     = DIR_N + 2 * PHASE_ITEMS + 150;

  // one directed row: request plus an optional hand-written expectation
  typedef struct packed {
    logic           command;
    logic [31:0]    delay;
    logic           typed;
    dtts_pkg::rsp_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic req_valid_i = 1'b0;
  dtts_pkg::req_t req_i = '0;
  logic rsp_stall_i = 1'b0;
  logic req_stall_o;
  logic rsp_valid_o;
  dtts_pkg::rsp_t rsp_o;

  dtts_pkg::rsp_t pending_settings[$];
  int unsigned mismatches  = 0;
  int unsigned rsp_seen    = 0;
  int unsigned tx_idle_pct = 35;
  int unsigned rx_idle_pct = 78;

  dir_row_t dir_rows [DIR_N] = '{
    '{dtts_pkg::CMD_BLOCKING, 32'd0, 1'b1,
      '{dtts_pkg::TIMER_8BIT, dtts_pkg::PRESC_DIV1, 11'd1, 16'd255, 1'b0, 16'd0}},
    '{dtts_pkg::CMD_BLOCKING, 32'd16, 1'b1,
      '{dtts_pkg::TIMER_8BIT, dtts_pkg::PRESC_DIV1, 11'd1, 16'd255, 1'b0, 16'd0}},
    '{dtts_pkg::CMD_BLOCKING, 32'd17, 1'b0, '0},
    '{dtts_pkg::CMD_BLOCKING, 32'd128, 1'b0, '0},
    '{dtts_pkg::CMD_BLOCKING, 32'd129, 1'b0, '0},
    '{dtts_pkg::CMD_BLOCKING, 32'd1024, 1'b0, '0},
    '{dtts_pkg::CMD_BLOCKING, 32'd1025, 1'b0, '0},
    '{dtts_pkg::CMD_BLOCKING, 32'd4097, 1'b0, '0},
    '{dtts_pkg::CMD_BLOCKING, 32'd16383, 1'b0, '0},
    '{dtts_pkg::CMD_BLOCKING, 32'd16384, 1'b0, '0},
    '{dtts_pkg::CMD_BLOCKING, 32'd4194336, 1'b1,
      '{dtts_pkg::TIMER_16BIT, dtts_pkg::PRESC_DIV1024, 11'd1, 16'd65535, 1'b1, 16'd0}},
    '{dtts_pkg::CMD_BLOCKING, 32'hFFFF_FFFF, 1'b1,
      '{dtts_pkg::TIMER_16BIT, dtts_pkg::PRESC_DIV1024, 11'd1024, 16'd65535, 1'b0, 16'd0}},
    '{dtts_pkg::CMD_NONBLOCK, 32'd0, 1'b1,
      '{dtts_pkg::TIMER_NONBLOCK, dtts_pkg::PRESC_DIV1, 11'd1, 16'd65535, 1'b0, 16'd0}},
    '{dtts_pkg::CMD_NONBLOCK, 32'd4096, 1'b0, '0},
    '{dtts_pkg::CMD_NONBLOCK, 32'd4097, 1'b0, '0},
    '{dtts_pkg::CMD_NONBLOCK, 32'd32769, 1'b0, '0},
    '{dtts_pkg::CMD_NONBLOCK, 32'd32770, 1'b0, '0},
    '{dtts_pkg::CMD_NONBLOCK, 32'd262145, 1'b0, '0},
    '{dtts_pkg::CMD_NONBLOCK, 32'd1048576, 1'b0, '0},
    '{dtts_pkg::CMD_NONBLOCK, 32'd1048577, 1'b0, '0},
    '{dtts_pkg::CMD_NONBLOCK, 32'd4194335, 1'b0, '0},
    '{dtts_pkg::CMD_NONBLOCK, 32'hFFFF_FFFF, 1'b1,
      '{dtts_pkg::TIMER_NONBLOCK, dtts_pkg::PRESC_DIV1024, 11'd1024, 16'd65535, 1'b0,
        16'd0}},
    '{dtts_pkg::CMD_NONBLOCK, 32'h5555_5555, 1'b0, '0},
    '{dtts_pkg::CMD_BLOCKING, 32'hAAAA_AAAA, 1'b0, '0}
  };

  delay_to_timer_settings_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("delay_to_timer_settings_top test failed");
    $finish;
  end

  // timer, prescaler and compare settings for one request
  function automatic dtts_pkg::rsp_t timer_settings_for(dtts_pkg::req_t r);
    dtts_pkg::timer_e    tid;
    dtts_pkg::prescale_e pc;
    int unsigned         sh;
    logic [63:0]         scaled;
    logic [63:0]         ticks;
    logic [63:0]         span;
    logic [63:0]         rem;
    dtts_pkg::rsp_t      o;
    if (r.command == dtts_pkg::CMD_NONBLOCK) tid = dtts_pkg::TIMER_NONBLOCK;
    else if (r.delay_us < 32'd16384) tid = dtts_pkg::TIMER_8BIT;
    else tid = dtts_pkg::TIMER_16BIT;
    // prescaler ladders
    if (tid == dtts_pkg::TIMER_8BIT) begin
      if (r.delay_us <= 32'd16) pc = dtts_pkg::PRESC_DIV1;
      else if (r.delay_us <= 32'd128) pc = dtts_pkg::PRESC_DIV8;
      else if (r.delay_us <= 32'd1024) pc = dtts_pkg::PRESC_DIV64;
      else if (r.delay_us <= 32'd4096) pc = dtts_pkg::PRESC_DIV256;
      else pc = dtts_pkg::PRESC_DIV1024;
    end else begin
      if (r.delay_us <= 32'd4096) pc = dtts_pkg::PRESC_DIV1;
      else if (r.delay_us <= 32'd32768) pc = dtts_pkg::PRESC_DIV8;
      else if (r.delay_us <= 32'd262144) pc = dtts_pkg::PRESC_DIV64;
      else if (r.delay_us <= 32'd1048576) pc = dtts_pkg::PRESC_DIV256;
      else pc = dtts_pkg::PRESC_DIV1024;
    end
    case (pc)
      dtts_pkg::PRESC_DIV1:   sh = 0;
      dtts_pkg::PRESC_DIV8:   sh = 3;
      dtts_pkg::PRESC_DIV64:  sh = 6;
      dtts_pkg::PRESC_DIV256: sh = 8;
      default:                sh = 10;
    endcase
    // 8-bit timer rounds up, the others round half away from zero
    scaled = 64'(r.delay_us) << 4;
    if (tid == dtts_pkg::TIMER_8BIT) ticks = (scaled + ((64'd1 << sh) - 64'd1)) >> sh;
    else ticks = (scaled + ((64'd1 << sh) >> 1)) >> sh;
    span = (tid == dtts_pkg::TIMER_NONBLOCK) ? 64'(dtts_pkg::NONBLOCK_TIMER_SPAN) :
                                               64'(dtts_pkg::WIDE_TIMER_SPAN);
    o = '0;
    o.timer_id      = tid;
    o.prescale_code = pc;
    o.cycle_count   = dtts_pkg::CYCLE_W'(1);
    // long delays split into full periods plus a shorter tail
    if (tid != dtts_pkg::TIMER_8BIT && pc == dtts_pkg::PRESC_DIV1024 && ticks > span) begin
      rem = ticks % span;
      o.cycle_count   = dtts_pkg::CYCLE_W'(ticks / span);
      o.compare_value = dtts_pkg::CMP_W'(span - 64'd1);
      if (rem != 64'd0) begin
        o.partial_flag    = 1'b1;
        o.partial_compare = dtts_pkg::CMP_W'(rem - 64'd1);
      end
    end else if (tid == dtts_pkg::TIMER_8BIT) begin
      o.compare_value = {8'd0, 8'(ticks - 64'd1)};
    end else begin
      o.compare_value = dtts_pkg::CMP_W'(ticks - 64'd1);
    end
    return o;
  endfunction

  // random request, weighted toward ladder edges and the split region
  function automatic dtts_pkg::req_t random_request();
    dtts_pkg::req_t r;
    logic [31:0]    base;
    r.command = 1'($urandom_range(1));
    case ($urandom_range(9))
      0, 1: r.delay_us = $urandom();
      2:    r.delay_us = $urandom_range(16383);
      3:    r.delay_us = $urandom_range(4096);
      4:    r.delay_us = $urandom_range(1048576);
      5: begin
        case ($urandom_range(9))
          0:       base = 32'd16;
          1:       base = 32'd128;
          2:       base = 32'd1024;
          3:       base = 32'd4096;
          4:       base = 32'd16384;
          5:       base = 32'd32768;
          6:       base = 32'd262144;
          7:       base = 32'd1048576;
          8:       base = 32'd4194304;
          default: base = 32'd4194336;
        endcase
        r.delay_us = base + $urandom_range(4) - 32'd2;
      end
      6:    r.delay_us = $urandom_range(67108863, 4194304);
      7:    r.delay_us = $urandom_range(255);
      8:    r.delay_us = (32'd1 << $urandom_range(31)) + $urandom_range(64) - 32'd32;
      default: r.delay_us = $urandom() >> $urandom_range(31);
    endcase
    return r;
  endfunction

  // offer one transaction, record its expectation once accepted
  task automatic offer_req(input dtts_pkg::req_t r, input logic typed,
                           input dtts_pkg::rsp_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (req_stall_o);
    if (typed) pending_settings.push_back(want);
    else pending_settings.push_back(timer_settings_for(r));
  endtask

  // lower valid and wait until every expected result is back
  task automatic drain_results();
    req_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_settings.size() != 0);
  endtask

  task automatic report_mismatch(input string fld, input int unsigned got,
                                 input int unsigned want);
    $display("result %0d: %s is %0d, expected %0d", rsp_seen, fld, got, want);
    mismatches++;
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    int unsigned hold_left;
    bit          held_once;
    hold_left = 0;
    held_once = 0;
    forever begin
      @(posedge clk_i);
      if (!held_once && rsp_seen >= HOLD_AT) begin
        held_once = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall_i <= 1'b1;
      end else begin
        rsp_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    dtts_pkg::rsp_t want;
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      if (pending_settings.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = pending_settings.pop_front();
        if (rsp_o.timer_id !== want.timer_id)
          report_mismatch("timer_id", rsp_o.timer_id, want.timer_id);
        if (rsp_o.prescale_code !== want.prescale_code)
          report_mismatch("prescale_code", rsp_o.prescale_code, want.prescale_code);
        if (rsp_o.cycle_count !== want.cycle_count)
          report_mismatch("cycle_count", rsp_o.cycle_count, want.cycle_count);
        if (rsp_o.compare_value !== want.compare_value)
          report_mismatch("compare_value", rsp_o.compare_value, want.compare_value);
        if (rsp_o.partial_flag !== want.partial_flag)
          report_mismatch("partial_flag", rsp_o.partial_flag, want.partial_flag);
        if (rsp_o.partial_compare !== want.partial_compare)
          report_mismatch("partial_compare", rsp_o.partial_compare, want.partial_compare);
      end
      rsp_seen++;
    end
  end

  // stimulus
  initial begin
    dtts_pkg::req_t r;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      r.command  = dir_rows[i].command;
      r.delay_us = dir_rows[i].delay;
      offer_req(r, dir_rows[i].typed, dir_rows[i].want);
    end
    drain_results();

    // random phases: receiver idles more, then sender, then neither
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 35; rx_idle_pct = 78; end
        1: begin tx_idle_pct = 78; rx_idle_pct = 35; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) offer_req(random_request(), 1'b0, '0);
      drain_results();
    end

    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("delay_to_timer_settings_top test passed");
    end else begin
      $display("delay_to_timer_settings_top test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dtts_pkg.sv
rtl/dtts_select.sv
rtl/delay_to_timer_settings_top.sv
sim/tb_delay_to_timer_settings_top.sv
